[hw/rtl/assert_macros.svh]
// Assertion macros shared by the memory map RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define HCMM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hcmm: required property violated");
// cond must never be seen at a clock edge outside reset
`define HCMM_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hcmm: forbidden condition seen");
`else
`define HCMM_ASSERT(label, clk, rst_n, prop)
`define HCMM_NEVER(label, clk, rst_n, cond)
`endif
`endif

[hw/rtl/hcmm_pkg.sv]
// Types, function codes, map constants, address decode and boot image
// for the handheld console memory map. No dependencies.
package hcmm_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HI,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        RG_NONE,
        RG_BOOT,
        RG_ROM,
        RG_VRAM,
        RG_ERAM,
        RG_WRAM,
        RG_OAM,
        RG_IO,
        RG_VREG,
        RG_HRAM,
        RG_IE
    } region_t;

    localparam logic [2:0] FN_RD_BYTE = 3'd0;
    localparam logic [2:0] FN_WR_BYTE = 3'd1;
    localparam logic [2:0] FN_RD_WORD = 3'd2;
    localparam logic [2:0] FN_WR_WORD = 3'd3;
    localparam logic [2:0] FN_LOAD    = 3'd4;

    localparam logic [15:0] VRAM_BASE     = 16'h8000;
    localparam logic [15:0] ERAM_BASE     = 16'hA000;
    localparam logic [15:0] WRAM_BASE     = 16'hC000;
    localparam logic [15:0] OAM_BASE      = 16'hFE00;
    localparam logic [15:0] OAM_END       = 16'hFEA0;
    localparam logic [15:0] IO_BASE       = 16'hFF00;
    localparam logic [15:0] IO_END        = 16'hFF10;
    localparam logic [15:0] VREG_BASE     = 16'hFF40;
    localparam logic [15:0] HRAM_BASE     = 16'hFF80;
    localparam logic [15:0] IE_ADDR       = 16'hFFFF;
    localparam logic [15:0] BOOT_REG_ADDR = 16'hFF50;

    localparam int OAM_BYTES  = 160;
    localparam int OAM_AW     = 8;
    localparam int IO_BYTES   = 16;
    localparam int IO_AW      = 4;
    localparam int VREG_BYTES = 64;
    localparam int VREG_AW    = 6;
    localparam int HRAM_BYTES = 128;
    localparam int HRAM_AW    = 7;

    localparam logic [7:0] BOOT_IMAGE [256] = '{
        8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,
        8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
        8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,
        8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
        8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,
        8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
        8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,
        8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
        8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,
        8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
        8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,
        8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
        8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,
        8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
        8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,
        8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
        8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hF2,8'hF0,8'h42,
        8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
        8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,
        8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
        8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,
        8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
        8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,
        8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
        8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,
        8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
        8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,
        8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h4C,
        8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,
        8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
        8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,
        8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
    };

    // Region of one CPU byte address; the boot overlay hides the low page
    // of ROM until the boot-done flag is set.
    function automatic region_t decode(input logic [15:0] a, input logic boot_done);
        region_t r;
        priority if (!boot_done && a[15:8] == 8'h00) r = RG_BOOT;
        else if (a < VRAM_BASE) r = RG_ROM;
        else if (a < ERAM_BASE) r = RG_VRAM;
        else if (a < WRAM_BASE) r = RG_ERAM;
        else if (a < OAM_BASE)  r = RG_WRAM;   // includes the echo space
        else if (a < OAM_END)   r = RG_OAM;
        else if (a < IO_BASE)   r = RG_NONE;
        else if (a == IE_ADDR)  r = RG_IE;
        else if (a < IO_END)    r = RG_IO;
        else if (a < VREG_BASE) r = RG_NONE;
        else if (a < HRAM_BASE) r = RG_VREG;
        else                    r = RG_HRAM;
        return r;
    endfunction

endpackage

[hw/rtl/handheld_console_memory_map_core.sv]
// Memory map core: region decode, region memories and access sequencer.
// Depends on hcmm_pkg and assert_macros.svh.
//
// Decodes 16-bit CPU addresses onto the console's regions and serves byte
// reads/writes, little-endian word reads/writes (low byte at addr, high byte
// at addr+1 wrapping at 0xFFFF) and cartridge ROM load beats. Every region
// memory is synchronous with registered read data. A word access issues its
// high byte from the held item while in_stall is high; a new item can be
// taken while the last result loads into the output register, if it is free.
// After reset a clearing pass over RAM_BYTES addresses (8192 by default)
// zeroes the RAMs, sprite table and register files; in_stall stays high for
// its duration. Cartridge ROM is not cleared: read only bytes you loaded.
`include "assert_macros.svh"

module handheld_console_memory_map_core #(
    parameter int ROM_BANK_BYTES = 16384,
    parameter int RAM_BYTES      = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [15:0] addr,
    input  logic [15:0] wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] rdata
);

    localparam int ROM_BYTES = 2 * ROM_BANK_BYTES;
    localparam int ROM_AW    = $clog2(ROM_BYTES);
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam logic [RAM_AW-1:0] CLEAR_LAST = RAM_AW'(RAM_BYTES - 1);

    hcmm_pkg::state_t  state_reg, state_next, acc_state;
    hcmm_pkg::region_t rsel_reg, op_region;

    logic [2:0]        func_reg;
    logic [15:0]       addr_reg, wdata_reg;
    logic [7:0]        lo_reg;
    logic [RAM_AW-1:0] clear_idx_reg;
    logic              boot_done_reg;
    logic [7:0]        irq_enable_reg;
    logic              out_valid_reg;
    logic [15:0]       rdata_reg, rdata_next;

    logic        accept, out_free, load_out, clearing, issue_en, cpu_we, rom_we;
    logic [2:0]  op_func;
    logic [15:0] op_addr;
    logic [7:0]  op_data, byte_rd;

    // region memories and their read registers
    logic [7:0] rom_mem  [ROM_BYTES];
    logic [7:0] vram_mem [RAM_BYTES];
    logic [7:0] eram_mem [RAM_BYTES];
    logic [7:0] wram_mem [RAM_BYTES];
    logic [7:0] oam_mem  [hcmm_pkg::OAM_BYTES];
    logic [7:0] io_mem   [hcmm_pkg::IO_BYTES];
    logic [7:0] vreg_mem [hcmm_pkg::VREG_BYTES];
    logic [7:0] hram_mem [hcmm_pkg::HRAM_BYTES];
    logic [7:0] rom_rd_reg, vram_rd_reg, eram_rd_reg, wram_rd_reg;
    logic [7:0] oam_rd_reg, io_rd_reg, vreg_rd_reg, hram_rd_reg;
    logic [7:0] boot_rd_reg, ie_rd_reg;

    logic                      vram_we, eram_we, wram_we, oam_we, io_we, vreg_we, hram_we;
    logic [RAM_AW-1:0]         ram_waddr;
    logic [hcmm_pkg::OAM_AW-1:0]  oam_waddr;
    logic [hcmm_pkg::IO_AW-1:0]   io_waddr;
    logic [hcmm_pkg::VREG_AW-1:0] vreg_waddr;
    logic [hcmm_pkg::HRAM_AW-1:0] hram_waddr;
    logic [7:0]                wr_data;

    // ---------------------------------------------------------------
    // Handshake and access issue
    // ---------------------------------------------------------------
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;
    assign clearing = (state_reg == hcmm_pkg::ST_CLEAR);
    assign load_out = (state_reg == hcmm_pkg::ST_DONE) && out_free;

    // byte 0 issues straight from the input beat, byte 1 from the held item
    assign issue_en = accept || (state_reg == hcmm_pkg::ST_HI);
    assign op_func  = (state_reg == hcmm_pkg::ST_HI) ? func_reg : func;
    assign op_addr  = (state_reg == hcmm_pkg::ST_HI) ? addr_reg + 16'd1 : addr;
    assign op_data  = (state_reg == hcmm_pkg::ST_HI) ? wdata_reg[15:8] : wdata[7:0];

    assign op_region = hcmm_pkg::decode(op_addr, boot_done_reg);
    assign cpu_we    = issue_en &&
                       (op_func == hcmm_pkg::FN_WR_BYTE || op_func == hcmm_pkg::FN_WR_WORD);
    assign rom_we    = issue_en && (op_func == hcmm_pkg::FN_LOAD) &&
                       ({16'h0000, op_addr} < 32'(ROM_BYTES));

    assign acc_state = (func == hcmm_pkg::FN_RD_WORD || func == hcmm_pkg::FN_WR_WORD)
                       ? hcmm_pkg::ST_HI : hcmm_pkg::ST_DONE;

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcmm_pkg::ST_CLEAR:
            begin
                if (clear_idx_reg == CLEAR_LAST)
                    state_next = hcmm_pkg::ST_IDLE;
            end
            hcmm_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = acc_state;
            end
            hcmm_pkg::ST_HI:
            begin
                state_next = hcmm_pkg::ST_DONE;
            end
            hcmm_pkg::ST_DONE:
            begin
                priority if (accept)
                    state_next = acc_state;
                else if (out_free)
                    state_next = hcmm_pkg::ST_IDLE;
                else
                    state_next = hcmm_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            hcmm_pkg::ST_CLEAR: in_stall = 1'b1;
            hcmm_pkg::ST_IDLE:  in_stall = 1'b0;
            hcmm_pkg::ST_HI:    in_stall = 1'b1;
            hcmm_pkg::ST_DONE:  in_stall = !out_free;  // next beat overlaps result load
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcmm_pkg::ST_CLEAR;
            clear_idx_reg  <= '0;
            boot_done_reg  <= 1'b0;
            irq_enable_reg <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clear_idx_reg <= clear_idx_reg + RAM_AW'(1);
            if (cpu_we && op_region == hcmm_pkg::RG_VREG &&
                op_addr == hcmm_pkg::BOOT_REG_ADDR && op_data != 8'h00)
                boot_done_reg <= 1'b1;
            if (cpu_we && op_region == hcmm_pkg::RG_IE)
                irq_enable_reg <= op_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            addr_reg  <= addr;
            wdata_reg <= wdata;
        end
        if (issue_en)
            rsel_reg <= op_region;
        if (state_reg == hcmm_pkg::ST_HI)
            lo_reg <= byte_rd;
        if (load_out)
            rdata_reg <= rdata_next;
    end

    // ---------------------------------------------------------------
    // Read data select
    // ---------------------------------------------------------------
    always_comb
    begin
        unique case (rsel_reg)
            hcmm_pkg::RG_NONE: byte_rd = 8'h00;
            hcmm_pkg::RG_BOOT: byte_rd = boot_rd_reg;
            hcmm_pkg::RG_ROM:  byte_rd = rom_rd_reg;
            hcmm_pkg::RG_VRAM: byte_rd = vram_rd_reg;
            hcmm_pkg::RG_ERAM: byte_rd = eram_rd_reg;
            hcmm_pkg::RG_WRAM: byte_rd = wram_rd_reg;
            hcmm_pkg::RG_OAM:  byte_rd = oam_rd_reg;
            hcmm_pkg::RG_IO:   byte_rd = io_rd_reg;
            hcmm_pkg::RG_VREG: byte_rd = vreg_rd_reg;
            hcmm_pkg::RG_HRAM: byte_rd = hram_rd_reg;
            hcmm_pkg::RG_IE:   byte_rd = ie_rd_reg;
            default:           byte_rd = 8'h00;
        endcase
    end

    always_comb
    begin
        priority if (func_reg == hcmm_pkg::FN_RD_WORD)
            rdata_next = {byte_rd, lo_reg};
        else if (func_reg == hcmm_pkg::FN_RD_BYTE)
            rdata_next = {8'h00, byte_rd};
        else
            rdata_next = 16'h0000;
    end

    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;

    // ---------------------------------------------------------------
    // Region memories; the clearing pass shares the write port
    // ---------------------------------------------------------------
    assign wr_data    = clearing ? 8'h00 : op_data;
    assign ram_waddr  = clearing ? clear_idx_reg : op_addr[RAM_AW-1:0];
    assign oam_waddr  = clearing ? clear_idx_reg[hcmm_pkg::OAM_AW-1:0]
                                 : op_addr[hcmm_pkg::OAM_AW-1:0];
    assign io_waddr   = clearing ? clear_idx_reg[hcmm_pkg::IO_AW-1:0]
                                 : op_addr[hcmm_pkg::IO_AW-1:0];
    assign vreg_waddr = clearing ? clear_idx_reg[hcmm_pkg::VREG_AW-1:0]
                                 : op_addr[hcmm_pkg::VREG_AW-1:0];
    assign hram_waddr = clearing ? clear_idx_reg[hcmm_pkg::HRAM_AW-1:0]
                                 : op_addr[hcmm_pkg::HRAM_AW-1:0];

    assign vram_we = clearing || (cpu_we && op_region == hcmm_pkg::RG_VRAM);
    assign eram_we = clearing || (cpu_we && op_region == hcmm_pkg::RG_ERAM);
    assign wram_we = clearing || (cpu_we && op_region == hcmm_pkg::RG_WRAM);
    assign oam_we  = (clearing && clear_idx_reg < RAM_AW'(hcmm_pkg::OAM_BYTES)) ||
                     (cpu_we && op_region == hcmm_pkg::RG_OAM);
    assign io_we   = clearing || (cpu_we && op_region == hcmm_pkg::RG_IO);
    assign vreg_we = clearing || (cpu_we && op_region == hcmm_pkg::RG_VREG);
    assign hram_we = clearing || (cpu_we && op_region == hcmm_pkg::RG_HRAM);

    always_ff @(posedge clk)
    begin
        if (rom_we)
            rom_mem[op_addr[ROM_AW-1:0]] <= op_data;
        if (issue_en)
            rom_rd_reg <= rom_mem[op_addr[ROM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram_mem[ram_waddr] <= wr_data;
        if (issue_en)
            vram_rd_reg <= vram_mem[op_addr[RAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (eram_we)
            eram_mem[ram_waddr] <= wr_data;
        if (issue_en)
            eram_rd_reg <= eram_mem[op_addr[RAM_AW-1:0]];
    end

    // echo space lands here through the low address bits
    always_ff @(posedge clk)
    begin
        if (wram_we)
            wram_mem[ram_waddr] <= wr_data;
        if (issue_en)
            wram_rd_reg <= wram_mem[op_addr[RAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
            oam_mem[oam_waddr] <= wr_data;
        if (issue_en && op_region == hcmm_pkg::RG_OAM)
            oam_rd_reg <= oam_mem[op_addr[hcmm_pkg::OAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (io_we)
            io_mem[io_waddr] <= wr_data;
        if (issue_en)
            io_rd_reg <= io_mem[op_addr[hcmm_pkg::IO_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vreg_we)
            vreg_mem[vreg_waddr] <= wr_data;
        if (issue_en)
            vreg_rd_reg <= vreg_mem[op_addr[hcmm_pkg::VREG_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hram_we)
            hram_mem[hram_waddr] <= wr_data;
        if (issue_en)
            hram_rd_reg <= hram_mem[op_addr[hcmm_pkg::HRAM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (issue_en)
        begin
            boot_rd_reg <= hcmm_pkg::BOOT_IMAGE[op_addr[7:0]];
            ie_rd_reg   <= irq_enable_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `HCMM_NEVER(a_no_beat_in_clear, clk, rst_n, clearing && !in_stall)
    `HCMM_ASSERT(a_clear_full_pass, clk, rst_n, (clearing && state_next != hcmm_pkg::ST_CLEAR) |-> (clear_idx_reg == CLEAR_LAST))
    `HCMM_ASSERT(a_hi_only_word, clk, rst_n, (state_reg == hcmm_pkg::ST_HI) |-> (func_reg == hcmm_pkg::FN_RD_WORD || func_reg == hcmm_pkg::FN_WR_WORD))
    `HCMM_ASSERT(a_nonread_zero, clk, rst_n, (load_out && func_reg != hcmm_pkg::FN_RD_BYTE && func_reg != hcmm_pkg::FN_RD_WORD) |=> (rdata == 16'h0000))
    `HCMM_NEVER(a_boot_done_sticky, clk, rst_n, $fell(boot_done_reg))

endmodule

[test/handheld_console_memory_map_core_test.sv]
// Self-checking testbench for handheld_console_memory_map_core: directed and
// random CPU bus traffic, checked against an in-bench model of the memory map.
// Depends on hcmm_pkg and the core RTL.
module handheld_console_memory_map_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FN_RSVD5 = 3'd5;
    localparam logic [2:0] FN_RSVD6 = 3'd6;
    localparam logic [2:0] FN_RSVD7 = 3'd7;

    localparam logic [15:0] BOOT_PAGE_END = 16'h0100;
    localparam logic [15:0] ECHO_BASE     = 16'hE000;
    localparam int          ECHO_BYTES    = 'h1E00;
    localparam int          ROM_BYTES     = 32768;
    localparam int          MAP_RAM_BYTES = 8192;
    localparam int          WINDOW        = 16;
    localparam int          IDLE_PCT      = 17;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 16;
    // nothing is accepted during the clearing pass after reset
    localparam int          WATCHDOG_LIMIT = 50000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [2:0]  func      = hcmm_pkg::FN_RD_BYTE;
    logic [15:0] addr      = 16'h0000;
    logic [15:0] wdata     = 16'h0000;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] rdata;

    handheld_console_memory_map_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .addr      (addr),
        .wdata     (wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rdata     (rdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---- memory map image ----
    logic [7:0] rom_image [0:ROM_BYTES-1]     = '{default: 8'h00};
    bit         rom_written [0:ROM_BYTES-1]   = '{default: 1'b0};
    logic [7:0] vram_img [0:MAP_RAM_BYTES-1]  = '{default: 8'h00};
    logic [7:0] eram_img [0:MAP_RAM_BYTES-1]  = '{default: 8'h00};
    logic [7:0] wram_img [0:MAP_RAM_BYTES-1]  = '{default: 8'h00};
    logic [7:0] oam_img [0:hcmm_pkg::OAM_BYTES-1]   = '{default: 8'h00};
    logic [7:0] io_img [0:hcmm_pkg::IO_BYTES-1]     = '{default: 8'h00};
    logic [7:0] vreg_img [0:hcmm_pkg::VREG_BYTES-1] = '{default: 8'h00};
    logic [7:0] hram_img [0:hcmm_pkg::HRAM_BYTES-1] = '{default: 8'h00};
    logic [7:0] ie_reg        = 8'h00;
    bit         boot_released = 1'b0;

    logic [15:0] expected_rdata [$];
    logic [15:0] want;
    int          mismatches   = 0;
    int          stuck_cycles = 0;
    int          hold_len     = 0;
    int          hold_cnt     = 0;
    bit          quiet        = 1'b0;

    function automatic logic [7:0] map_read_byte(input logic [15:0] a);
        if (!boot_released && a < BOOT_PAGE_END) return hcmm_pkg::BOOT_IMAGE[a[7:0]];
        if (a < hcmm_pkg::VRAM_BASE) return rom_image[a[14:0]];
        if (a < hcmm_pkg::ERAM_BASE) return vram_img[a[12:0]];
        if (a < hcmm_pkg::WRAM_BASE) return eram_img[a[12:0]];
        if (a < hcmm_pkg::OAM_BASE)  return wram_img[a[12:0]];   // echo folds onto work RAM
        if (a < hcmm_pkg::OAM_END)   return oam_img[a[7:0]];
        if (a < hcmm_pkg::IO_BASE)   return 8'h00;
        if (a == hcmm_pkg::IE_ADDR)  return ie_reg;
        if (a < hcmm_pkg::IO_END)    return io_img[a[3:0]];
        if (a < hcmm_pkg::VREG_BASE) return 8'h00;
        if (a < hcmm_pkg::HRAM_BASE) return vreg_img[a[5:0]];
        return hram_img[a[6:0]];
    endfunction

    function automatic void map_write_byte(input logic [15:0] a, input logic [7:0] d);
        if (a < hcmm_pkg::VRAM_BASE)      return;
        else if (a < hcmm_pkg::ERAM_BASE) vram_img[a[12:0]] = d;
        else if (a < hcmm_pkg::WRAM_BASE) eram_img[a[12:0]] = d;
        else if (a < hcmm_pkg::OAM_BASE)  wram_img[a[12:0]] = d;
        else if (a < hcmm_pkg::OAM_END)   oam_img[a[7:0]] = d;
        else if (a < hcmm_pkg::IO_BASE)   return;
        else if (a == hcmm_pkg::IE_ADDR)  ie_reg = d;
        else if (a < hcmm_pkg::IO_END)    io_img[a[3:0]] = d;
        else if (a < hcmm_pkg::VREG_BASE) return;
        else if (a < hcmm_pkg::HRAM_BASE)
        begin
            vreg_img[a[5:0]] = d;
            if (a == hcmm_pkg::BOOT_REG_ADDR && d != 8'h00) boot_released = 1'b1;
        end
        else hram_img[a[6:0]] = d;
    endfunction

    // Applies one accepted beat to the image and returns the rdata it yields.
    function automatic logic [15:0] map_access(input logic [2:0] f, input logic [15:0] a,
                                               input logic [15:0] d);
        logic [15:0] a_next;
        logic [15:0] r;
        a_next = a + 16'd1;
        r = 16'h0000;
        case (f)
            hcmm_pkg::FN_RD_BYTE: r = {8'h00, map_read_byte(a)};
            hcmm_pkg::FN_WR_BYTE: map_write_byte(a, d[7:0]);
            hcmm_pkg::FN_RD_WORD:
            begin
                r[7:0]  = map_read_byte(a);
                r[15:8] = map_read_byte(a_next);
            end
            hcmm_pkg::FN_WR_WORD:
            begin
                map_write_byte(a, d[7:0]);
                map_write_byte(a_next, d[15:8]);
            end
            hcmm_pkg::FN_LOAD:
            begin
                if (a < hcmm_pkg::VRAM_BASE)
                begin
                    rom_image[a[14:0]] = d[7:0];
                    rom_written[a[14:0]] = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ROM bytes that were never loaded must not be read
    function automatic bit can_read(input logic [15:0] a);
        if (!boot_released && a < BOOT_PAGE_END) return 1'b1;
        if (a < hcmm_pkg::VRAM_BASE) return rom_written[a[14:0]];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        if (mismatches < 50)
            $display("mismatch %s: got %h, expected %h at %0t", what, got, exp_val, $realtime);
        mismatches++;
    endtask

    // ---- sender ----
    task automatic send_access(input logic [2:0] f, input logic [15:0] a,
                               input logic [15:0] d);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        addr     <= a;
        wdata    <= d;
        do @(posedge clk); while (in_stall);
        expected_rdata.push_back(map_access(f, a, d));
    endtask

    // ---- receiver: random stall plus an occasional long hold-off ----
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt--;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ---- result checker ----
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rdata.size() == 0)
                report_mismatch("unexpected beat", rdata, 16'h0000);
            else
            begin
                want = expected_rdata.pop_front();
                if (rdata !== want) report_mismatch("rdata", rdata, want);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---- random traffic ----
    function automatic logic [15:0] pick_in(input logic [15:0] base, input int span);
        int off;
        off = ($urandom_range(0, 1) != 0) ? $urandom_range(0, WINDOW - 1)
                                          : $urandom_range(0, span - 1);
        return base + off[15:0];
    endfunction

    // ROM offsets cluster around the bank edges so loads and reads meet
    function automatic logic [15:0] pick_rom();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 'h01FF));
            1:       return 16'($urandom_range('h3FC0, 'h403F));
            2:       return 16'($urandom_range('h7FC0, 'h7FFF));
            default: return 16'($urandom_range(0, 'h7FFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_cpu_addr();
        case ($urandom_range(0, 11))
            0:  return pick_rom();
            1:  return pick_in(hcmm_pkg::VRAM_BASE, MAP_RAM_BYTES);
            2:  return pick_in(hcmm_pkg::ERAM_BASE, MAP_RAM_BYTES);
            3:  return pick_in(hcmm_pkg::WRAM_BASE, MAP_RAM_BYTES);
            4:  return pick_in(ECHO_BASE, ECHO_BYTES);
            5:  return pick_in(hcmm_pkg::OAM_BASE, hcmm_pkg::OAM_BYTES);
            6:  return ($urandom_range(0, 1) != 0) ? pick_in(hcmm_pkg::OAM_END, 'h60)
                                                   : pick_in(hcmm_pkg::IO_END, 'h30);
            7:  return pick_in(hcmm_pkg::IO_BASE, hcmm_pkg::IO_BYTES);
            8:  return pick_in(hcmm_pkg::VREG_BASE, hcmm_pkg::VREG_BYTES);
            9:  return pick_in(hcmm_pkg::HRAM_BASE, hcmm_pkg::HRAM_BYTES - 1);
            10: return ($urandom_range(0, 1) != 0) ? hcmm_pkg::IE_ADDR
                                                   : hcmm_pkg::BOOT_REG_ADDR;
            default: return 16'($urandom_range(0, 'hFFFF));
        endcase
    endfunction

    task automatic run_random(input int n);
        logic [2:0]  f;
        logic [15:0] a;
        logic [15:0] d;
        int          r;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2) quiet = 1'b1;
            if (i == n / 2 + 200) quiet = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 24)      f = hcmm_pkg::FN_RD_BYTE;
            else if (r < 44) f = hcmm_pkg::FN_WR_BYTE;
            else if (r < 64) f = hcmm_pkg::FN_RD_WORD;
            else if (r < 82) f = hcmm_pkg::FN_WR_WORD;
            else if (r < 96) f = hcmm_pkg::FN_LOAD;
            else
                case ($urandom_range(0, 2))
                    0:       f = FN_RSVD5;
                    1:       f = FN_RSVD6;
                    default: f = FN_RSVD7;
                endcase
            if (f == hcmm_pkg::FN_LOAD)
                a = ($urandom_range(0, 99) < 80) ? pick_rom() : 16'($urandom_range(0, 'hFFFF));
            else
                a = pick_cpu_addr();
            d = 16'($urandom_range(0, 'hFFFF));
            // a read that would touch unloaded ROM becomes a load at its address instead
            if ((f == hcmm_pkg::FN_RD_BYTE && !can_read(a)) ||
                (f == hcmm_pkg::FN_RD_WORD && !(can_read(a) && can_read(a + 16'd1))))
                f = hcmm_pkg::FN_LOAD;
            send_access(f, a, d);
        end
        quiet = 1'b0;
    endtask

    // ---- directed tests ----
    task automatic test_rom_load();
        send_access(hcmm_pkg::FN_LOAD, 16'h0000, 16'h005A);
        send_access(hcmm_pkg::FN_LOAD, 16'h0100, 16'h00C3);
        send_access(hcmm_pkg::FN_LOAD, 16'h3FFF, 16'h0011);
        send_access(hcmm_pkg::FN_LOAD, 16'h4000, 16'h0022);
        send_access(hcmm_pkg::FN_LOAD, 16'h7FFF, 16'hABFF);
        // offset too large, dropped
        send_access(hcmm_pkg::FN_LOAD, 16'h8000, 16'h0033);
        send_access(hcmm_pkg::FN_LOAD, 16'hFFFF, 16'h0044);
        send_access(hcmm_pkg::FN_RD_WORD, 16'h3FFF, 16'h0000);
        send_access(hcmm_pkg::FN_RD_BYTE, 16'h7FFF, 16'h0000);
    endtask

    task automatic test_boot_overlay();
        send_access(hcmm_pkg::FN_LOAD, 16'h00FF, 16'h0077);
        send_access(hcmm_pkg::FN_RD_BYTE, 16'h0000, 16'h0000);
        send_access(hcmm_pkg::FN_RD_WORD, 16'h00FF, 16'h0000);
        send_access(hcmm_pkg::FN_WR_BYTE, 16'h0010, 16'h00EE);
        // zero byte keeps overlay
        send_access(hcmm_pkg::FN_WR_BYTE, hcmm_pkg::BOOT_REG_ADDR, 16'hFF00);
        send_access(hcmm_pkg::FN_RD_WORD, hcmm_pkg::IE_ADDR, 16'h0000);
    endtask

    task automatic test_region_edges();
        send_access(hcmm_pkg::FN_WR_WORD, 16'h9FFF, 16'h1234);
        send_access(hcmm_pkg::FN_RD_WORD, 16'h9FFF, 16'h0000);
        send_access(hcmm_pkg::FN_WR_WORD, 16'hDFFF, 16'hBEEF);
        send_access(hcmm_pkg::FN_RD_BYTE, ECHO_BASE, 16'h0000);
        send_access(hcmm_pkg::FN_WR_WORD, 16'hFE9F, 16'h5566);
        send_access(hcmm_pkg::FN_RD_WORD, 16'hFE9F, 16'h0000);
        send_access(hcmm_pkg::FN_WR_WORD, 16'hFF3F, 16'h7788);
        send_access(hcmm_pkg::FN_RD_WORD, 16'hFF0F, 16'h0000);
        send_access(hcmm_pkg::FN_WR_WORD, 16'hFF7F, 16'h99AA);
        send_access(hcmm_pkg::FN_WR_WORD, 16'hFFFE, 16'hCCDD);
        send_access(hcmm_pkg::FN_RD_WORD, 16'hFFFE, 16'h0000);
    endtask

    task automatic test_unused_funcs();
        send_access(FN_RSVD5, hcmm_pkg::VRAM_BASE, 16'hFFFF);
        send_access(FN_RSVD6, hcmm_pkg::HRAM_BASE, 16'hFFFF);
        send_access(FN_RSVD7, 16'h0000, 16'hFFFF);
        send_access(hcmm_pkg::FN_RD_BYTE, hcmm_pkg::VRAM_BASE, 16'h0000);
    endtask

    task automatic test_boot_release();
        send_access(hcmm_pkg::FN_WR_BYTE, hcmm_pkg::BOOT_REG_ADDR, 16'h0001);
        send_access(hcmm_pkg::FN_RD_BYTE, 16'h0000, 16'h0000);
        send_access(hcmm_pkg::FN_RD_WORD, 16'h00FF, 16'h0000);
        send_access(hcmm_pkg::FN_RD_BYTE, hcmm_pkg::BOOT_REG_ADDR, 16'h0000);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        quiet = 1'b1;
        hold_len = HOLD_CYCLES;
        run_random(40);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rom_load();
        test_boot_overlay();
        test_region_edges();
        test_unused_funcs();
        run_random(600);
        test_boot_release();
        test_backpressure();
        run_random(1180);
        in_valid <= 1'b0;
        while (expected_rdata.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
